FILE: rtl/sgd_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and register codes for the staggered grid derivative
// no dependencies

package sgd_pkg;

   localparam int DEF_MAX_ORDER   = 6;
   localparam int DEF_SAMPLE_BITS = 24;

   localparam int ORDER_BITS      = 3;
   localparam int WEIGHT_BITS     = 18;
   localparam int INV_BITS        = 24;
   localparam int NUM_WEIGHT_REGS = 6;
   localparam int LO_BITS         = 24;

   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 5;

   localparam logic [ORDER_BITS-1:0] ORDER_RESET = 3'd1;
   localparam logic [INV_BITS-1:0]   INV_RESET   = 24'd65536;

   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;
   localparam logic [63:0] NEG_LIMIT  = 64'h0000_0000_8000_0000;
   localparam logic [31:0] POS_CLIP   = 32'h7fff_ffff;
   localparam logic [31:0] NEG_CLIP   = 32'h8000_0000;

   typedef enum logic [2:0] {
      REG_TAP_ORDER   = 3'd0,
      REG_WEIGHT_1    = 3'd1,
      REG_WEIGHT_2    = 3'd2,
      REG_WEIGHT_3    = 3'd3,
      REG_WEIGHT_4    = 3'd4,
      REG_WEIGHT_5    = 3'd5,
      REG_WEIGHT_6    = 3'd6,
      REG_INV_SPACING = 3'd7
   } sgd_reg_type;

   typedef struct packed {
      logic valid;
      logic last;
   } sgd_ctl_type;

endpackage

FILE: rtl/sgd_req_if.sv
`timescale 1ns / 1ps
// sample channel into the derivative block
// depends on sgd_pkg

interface sgd_req_if import sgd_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   line_end;

   modport source (output valid, sample, line_end, input ready);
   modport sink   (input valid, sample, line_end, output ready);
endinterface

FILE: rtl/sgd_rsp_if.sv
`timescale 1ns / 1ps
// derivative result channel out of the derivative block
// depends on sgd_pkg

interface sgd_rsp_if import sgd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_BITS-1:0] derivative;
   logic              last_in_line;
   logic              saturated;

   modport source (output valid, derivative, last_in_line, saturated, input ready);
   modport sink   (input valid, derivative, last_in_line, saturated, output ready);
endinterface

FILE: rtl/sgd_csr.sv
`timescale 1ns / 1ps
// apb register bank: stencil order, weights and reciprocal spacing
// depends on sgd_pkg

module sgd_csr import sgd_pkg::*; #(
   parameter int MAX_ORDER = DEF_MAX_ORDER
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ADDR_BITS-1:0]                  paddr,
   input  logic [DATA_BITS-1:0]                  pwdata,
   output logic [DATA_BITS-1:0]                  prdata,
   output logic                                  pready,
   output logic [ORDER_BITS-1:0]                 tap_order,
   output logic [MAX_ORDER-1:0][WEIGHT_BITS-1:0] tap_weight,
   output logic [INV_BITS-1:0]                   inv_spacing
);

   logic [ORDER_BITS-1:0]                 order_ff;
   logic [MAX_ORDER-1:0][WEIGHT_BITS-1:0] weight_ff;
   logic [INV_BITS-1:0]                   inv_ff;
   sgd_reg_type                           reg_idx;
   logic                                  wr_en;

   assign reg_idx = sgd_reg_type'(paddr[ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= ORDER_RESET;
         weight_ff <= '0;
         inv_ff    <= INV_RESET;
      end else if (wr_en) begin
         unique case (reg_idx) inside
            REG_TAP_ORDER: begin
               order_ff <= pwdata[ORDER_BITS-1:0];
            end
            REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3,
            REG_WEIGHT_4, REG_WEIGHT_5, REG_WEIGHT_6: begin
               for (int k = 0; k < MAX_ORDER; k++) begin
                  if (k < NUM_WEIGHT_REGS &&
                      int'(reg_idx) - int'(REG_WEIGHT_1) == k) begin
                     weight_ff[k] <= pwdata[WEIGHT_BITS-1:0];
                  end
               end
            end
            REG_INV_SPACING: begin
               inv_ff <= pwdata[INV_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx) inside
         REG_TAP_ORDER: begin
            prdata = {{(DATA_BITS-ORDER_BITS){1'b0}}, order_ff};
         end
         REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3,
         REG_WEIGHT_4, REG_WEIGHT_5, REG_WEIGHT_6: begin
            for (int k = 0; k < MAX_ORDER; k++) begin
               if (k < NUM_WEIGHT_REGS &&
                   int'(reg_idx) - int'(REG_WEIGHT_1) == k) begin
                  prdata = {{(DATA_BITS-WEIGHT_BITS){weight_ff[k][WEIGHT_BITS-1]}},
                            weight_ff[k]};
               end
            end
         end
         REG_INV_SPACING: begin
            prdata = {{(DATA_BITS-INV_BITS){1'b0}}, inv_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign tap_order   = order_ff;
   assign tap_weight  = weight_ff;
   assign inv_spacing = inv_ff;

endmodule

FILE: rtl/sgd_window.sv
`timescale 1ns / 1ps
// sample window shift line, line fill count and per-lane tap differences
// depends on sgd_pkg and sgd_req_if

module sgd_window import sgd_pkg::*; #(
   parameter int MAX_ORDER   = DEF_MAX_ORDER,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sgd_req_if.sink                               req_if,
   input  logic [ORDER_BITS-1:0]                 tap_order,
   output sgd_ctl_type                           dn_ctl,
   output logic [MAX_ORDER-1:0][SAMPLE_BITS:0]   dn_diff,
   input  logic                                  dn_ready
);

   localparam int WIN_DEPTH = 2 * MAX_ORDER - 1;
   localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
   localparam int ORD_W     = $clog2(MAX_ORDER + 1);

   logic [SAMPLE_BITS-1:0]              window_ff [WIN_DEPTH];
   logic [SAMPLE_BITS-1:0]              taps [WIN_DEPTH+1];
   logic [CNT_W-1:0]                    fill_ff;
   logic [CNT_W-1:0]                    fill_in;
   logic [CNT_W-1:0]                    need;
   logic [ORD_W-1:0]                    ord;
   logic                                ready;
   logic                                accept;
   logic                                produce;
   logic [MAX_ORDER-1:0][SAMPLE_BITS:0] diff_in;
   logic [MAX_ORDER-1:0][SAMPLE_BITS:0] diff_ff;
   sgd_ctl_type                         ctl_ff;

   assign ready        = !ctl_ff.valid || dn_ready;
   assign req_if.ready = ready;
   assign accept       = req_if.valid && ready;

   always_comb begin
      if (tap_order == '0) begin
         ord = ORD_W'(1);
      end else if (int'(tap_order) > MAX_ORDER) begin
         ord = ORD_W'(MAX_ORDER);
      end else begin
         ord = ORD_W'(tap_order);
      end
   end

   assign need    = CNT_W'(2 * int'(ord) - 1);
   assign produce = (fill_ff >= need);

   always_comb begin
      taps[0] = req_if.sample;
      for (int i = 1; i <= WIN_DEPTH; i++) begin
         taps[i] = window_ff[i-1];
      end
   end

   // lane k pairs the taps order-1-k and order+k
   always_comb begin
      diff_in = '0;
      for (int o = 1; o <= MAX_ORDER; o++) begin
         if (int'(ord) == o) begin
            for (int k = 0; k < o; k++) begin
               diff_in[k] = {taps[o-1-k][SAMPLE_BITS-1], taps[o-1-k]} -
                            {taps[o+k][SAMPLE_BITS-1], taps[o+k]};
            end
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (req_if.line_end) begin
         fill_in = '0;
      end else if (fill_ff < CNT_W'(WIN_DEPTH)) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff[0] <= req_if.sample;
         for (int i = 1; i < WIN_DEPTH; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (ready) begin
         ctl_ff.valid <= accept && produce;
         ctl_ff.last  <= req_if.line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         diff_ff <= diff_in;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_diff = diff_ff;

endmodule

FILE: rtl/sgd_mac_cell.sv
`timescale 1ns / 1ps
// one stencil cell: adds its weight times its lane difference to the partial sum
// depends on sgd_pkg

module sgd_mac_cell import sgd_pkg::*; #(
   parameter int MAX_ORDER   = DEF_MAX_ORDER,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int CELL_INDEX  = 0,
   parameter int ACC_BITS    = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [WEIGHT_BITS-1:0]              weight,
   input  sgd_ctl_type                         up_ctl,
   input  logic [ACC_BITS-1:0]                 up_psum,
   input  logic [MAX_ORDER-1:0][SAMPLE_BITS:0] up_diff,
   output logic                                up_ready,
   output sgd_ctl_type                         dn_ctl,
   output logic [ACC_BITS-1:0]                 dn_psum,
   output logic [MAX_ORDER-1:0][SAMPLE_BITS:0] dn_diff,
   input  logic                                dn_ready
);

   localparam int PROD_W = SAMPLE_BITS + 1 + WEIGHT_BITS;

   logic signed [PROD_W-1:0]            prod;
   logic [ACC_BITS-1:0]                 psum_in;
   logic [ACC_BITS-1:0]                 psum_ff;
   logic [MAX_ORDER-1:0][SAMPLE_BITS:0] diff_ff;
   sgd_ctl_type                         ctl_ff;

   assign up_ready = !ctl_ff.valid || dn_ready;

   assign prod    = $signed(weight) * $signed(up_diff[CELL_INDEX]);
   assign psum_in = up_psum + {{(ACC_BITS-PROD_W){prod[PROD_W-1]}}, prod};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (up_ready) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         psum_ff <= psum_in;
         diff_ff <= up_diff;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_psum = psum_ff;
   assign dn_diff = diff_ff;

endmodule

FILE: rtl/sgd_scale.sv
`timescale 1ns / 1ps
// reciprocal spacing scale with rounding and 32-bit saturation, result register
// depends on sgd_pkg and sgd_rsp_if

module sgd_scale import sgd_pkg::*; #(
   parameter int ACC_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [INV_BITS-1:0] inv_spacing,
   input  sgd_ctl_type         up_ctl,
   input  logic [ACC_BITS-1:0] up_psum,
   output logic                up_ready,
   sgd_rsp_if.source           rsp_if
);

   localparam int HI_W  = ACC_BITS - LO_BITS;
   localparam int SUM_W = (ACC_BITS + LO_BITS + 1 > 65) ? ACC_BITS + LO_BITS + 1 : 65;
   localparam int RES_W = SUM_W - 32;

   sgd_ctl_type                mag_ctl_ff;
   logic                       mag_neg_ff;
   logic [ACC_BITS-1:0]        mag_in;
   logic [ACC_BITS-1:0]        mag_ff;
   logic                       mag_ready;

   sgd_ctl_type                prd_ctl_ff;
   logic                       prd_neg_ff;
   logic [LO_BITS+INV_BITS-1:0] lo_in;
   logic [LO_BITS+INV_BITS-1:0] lo_ff;
   logic [HI_W+INV_BITS-1:0]   hi_in;
   logic [HI_W+INV_BITS-1:0]   hi_ff;
   logic                       prd_ready;

   logic [SUM_W-1:0]           sum_in;
   logic [RES_W-1:0]           res;
   logic                       pos_over;
   logic                       neg_over;
   logic                       sat_in;
   logic [DATA_BITS-1:0]       der_in;
   logic                       out_ready;

   logic                       out_valid_ff;
   logic                       out_last_ff;
   logic                       out_sat_ff;
   logic [DATA_BITS-1:0]       out_der_ff;

   assign out_ready = !out_valid_ff || rsp_if.ready;
   assign prd_ready = !prd_ctl_ff.valid || out_ready;
   assign mag_ready = !mag_ctl_ff.valid || prd_ready;
   assign up_ready  = mag_ready;

   // magnitude stage
   assign mag_in = up_psum[ACC_BITS-1] ? (~up_psum + ACC_BITS'(1)) : up_psum;

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ctl_ff <= '0;
      end else if (mag_ready) begin
         mag_ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (mag_ready) begin
         mag_neg_ff <= up_psum[ACC_BITS-1];
         mag_ff     <= mag_in;
      end
   end

   // partial products of magnitude times reciprocal spacing
   assign lo_in = mag_ff[LO_BITS-1:0] * inv_spacing;
   assign hi_in = mag_ff[ACC_BITS-1:LO_BITS] * inv_spacing;

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_ctl_ff <= '0;
      end else if (prd_ready) begin
         prd_ctl_ff <= mag_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prd_ready) begin
         prd_neg_ff <= mag_neg_ff;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
      end
   end

   // round half away from zero, drop 32 fraction bits, clip
   assign sum_in = SUM_W'({hi_ff, {LO_BITS{1'b0}}}) + SUM_W'(lo_ff) + SUM_W'(ROUND_HALF);
   assign res    = sum_in[SUM_W-1:32];

   assign pos_over = |res[RES_W-1:31];
   assign neg_over = res > RES_W'(NEG_LIMIT);
   assign sat_in   = prd_neg_ff ? neg_over : pos_over;

   always_comb begin
      if (sat_in) begin
         der_in = prd_neg_ff ? NEG_CLIP : POS_CLIP;
      end else if (prd_neg_ff) begin
         der_in = ~res[DATA_BITS-1:0] + DATA_BITS'(1);
      end else begin
         der_in = res[DATA_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= prd_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_last_ff <= prd_ctl_ff.last;
         out_sat_ff  <= sat_in;
         out_der_ff  <= der_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.derivative   = out_der_ff;
   assign rsp_if.last_in_line = out_last_ff;
   assign rsp_if.saturated    = out_sat_ff;

endmodule

FILE: rtl/staggered_grid_derivative.sv
`timescale 1ns / 1ps
// staggered grid first derivative over a streamed grid line
// pipeline: window, mac cells, then magnitude, product and output registers
// throughput: one sample per cycle unless back-pressured, one mac cell per stencil pair
// reset: synchronous, clears pipeline valids and line fill count, resets config registers
// depends on sgd_pkg, sgd_req_if, sgd_rsp_if, sgd_csr, sgd_window, sgd_mac_cell, sgd_scale

module staggered_grid_derivative import sgd_pkg::*; #(
   parameter int MAX_ORDER   = DEF_MAX_ORDER,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   sgd_req_if.sink              req_if,
   sgd_rsp_if.source            rsp_if,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   localparam int ACC_BITS = SAMPLE_BITS + WEIGHT_BITS + 2 + $clog2(MAX_ORDER);

   logic [ORDER_BITS-1:0]                 tap_order;
   logic [MAX_ORDER-1:0][WEIGHT_BITS-1:0] tap_weight;
   logic [INV_BITS-1:0]                   inv_spacing;

   sgd_ctl_type                         ctl  [MAX_ORDER+1];
   logic [ACC_BITS-1:0]                 psum [MAX_ORDER+1];
   logic [MAX_ORDER-1:0][SAMPLE_BITS:0] diff [MAX_ORDER+1];
   logic                                rdy  [MAX_ORDER+1];

   sgd_csr #(
      .MAX_ORDER (MAX_ORDER)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .tap_order   (tap_order),
      .tap_weight  (tap_weight),
      .inv_spacing (inv_spacing)
   );

   sgd_window #(
      .MAX_ORDER   (MAX_ORDER),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .tap_order (tap_order),
      .dn_ctl    (ctl[0]),
      .dn_diff   (diff[0]),
      .dn_ready  (rdy[0])
   );

   assign psum[0] = '0;

   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
      sgd_mac_cell #(
         .MAX_ORDER   (MAX_ORDER),
         .SAMPLE_BITS (SAMPLE_BITS),
         .CELL_INDEX  (k),
         .ACC_BITS    (ACC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .weight   (tap_weight[k]),
         .up_ctl   (ctl[k]),
         .up_psum  (psum[k]),
         .up_diff  (diff[k]),
         .up_ready (rdy[k]),
         .dn_ctl   (ctl[k+1]),
         .dn_psum  (psum[k+1]),
         .dn_diff  (diff[k+1]),
         .dn_ready (rdy[k+1])
      );
   end

   sgd_scale #(
      .ACC_BITS (ACC_BITS)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .inv_spacing (inv_spacing),
      .up_ctl      (ctl[MAX_ORDER]),
      .up_psum     (psum[MAX_ORDER]),
      .up_ready    (rdy[MAX_ORDER]),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: rtl/sgd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the staggered grid derivative, bound to the top level
// depends on staggered_grid_derivative

module sgd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_derivative,
   input logic        rsp_last_in_line,
   input logic        rsp_saturated
);

   // result transaction holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_derivative) && $stable(rsp_last_in_line)
                                  && $stable(rsp_saturated))
      else $error("result payload changed while stalled");

   // clipped results sit on a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_derivative == 32'h7fff_ffff || rsp_derivative == 32'h8000_0000)
      else $error("saturated result not at a rail");

   // empty pipeline after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("sample channel not ready after reset");

endmodule

bind staggered_grid_derivative sgd_checker u_sgd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_derivative   (rsp_if.derivative),
   .rsp_last_in_line (rsp_if.last_in_line),
   .rsp_saturated    (rsp_if.saturated)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for staggered_grid_derivative: directed and random sample lines
// depends on sgd_pkg, sgd_req_if, sgd_rsp_if and the staggered_grid_derivative rtl

module testbench;
   import sgd_pkg::*;

   localparam int WIN_DEPTH      = 2 * DEF_MAX_ORDER - 1;
   localparam int PIPE_LATENCY   = DEF_MAX_ORDER + 4;
   localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 100;
   localparam int PRINT_LIMIT    = 40;

   localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
   localparam logic signed [17:0] WEIGHT_MAX = 18'sh1FFFF;
   localparam logic signed [17:0] WEIGHT_MIN = 18'sh20000;

   typedef struct packed {
      logic [31:0] derivative;
      logic        last_in_line;
      logic        saturated;
   } deriv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   sgd_req_if samples ();
   sgd_rsp_if derivs ();

   staggered_grid_derivative dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (samples),
      .rsp_if  (derivs),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // stencil state mirrored from the register writes and accepted samples
   logic [2:0]         cfg_order = ORDER_RESET;
   logic signed [17:0] cfg_weight [NUM_WEIGHT_REGS] = '{default: '0};
   logic [23:0]        cfg_inv = INV_RESET;
   logic signed [23:0] sample_hist [WIN_DEPTH];
   int                 line_fill = 0;

   logic signed [17:0] weight_plan [NUM_WEIGHT_REGS];
   deriv_result_type   expected_derivs[$];

   int send_gap_max    = 8;
   int rsp_gap_max     = 8;
   int rsp_hold_cycles = 0;
   int quiet_cycles    = 0;
   int mismatch_count  = 0;
   int sample_count    = 0;
   int checked_count   = 0;
   int marked_count    = 0;
   int clipped_count   = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint tap_value(input logic signed [23:0] current, input int distance);
      if (distance == 0) return longint'(current);
      return longint'(sample_hist[distance-1]);
   endfunction

   task automatic predict_derivative(input logic signed [23:0] value, input logic last);
      int                 ord;
      int                 k;
      longint             acc;
      longint             diff;
      longint unsigned    mag;
      longint unsigned    res;
      deriv_result_type   want;
      ord = (cfg_order == 0) ? 1 : ((cfg_order > DEF_MAX_ORDER) ? DEF_MAX_ORDER : cfg_order);
      if (line_fill >= 2 * ord - 1) begin
         acc = 0;
         for (k = 0; k < ord; k++) begin
            diff = tap_value(value, ord - 1 - k) - tap_value(value, ord + k);
            acc += longint'(cfg_weight[k]) * diff;
         end
         mag = (acc < 0) ? -acc : acc;
         res = (mag >> 32) * cfg_inv + (((mag & 64'hFFFF_FFFF) * cfg_inv + ROUND_HALF) >> 32);
         want.saturated = 1'b0;
         want.last_in_line = last;
         if (acc >= 0) begin
            if (res > 64'(POS_CLIP)) begin
               res = 64'(POS_CLIP);
               want.saturated = 1'b1;
            end
            want.derivative = res[31:0];
         end else begin
            if (res > NEG_LIMIT) begin
               res = NEG_LIMIT;
               want.saturated = 1'b1;
            end
            want.derivative = -res[31:0];
         end
         expected_derivs.push_back(want);
      end
      for (k = WIN_DEPTH - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
      sample_hist[0] = value;
      if (last) line_fill = 0;
      else if (line_fill < WIN_DEPTH) line_fill++;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_sample(input logic signed [23:0] value, input logic last);
      int gap;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
      repeat (gap) begin
         @(negedge clock);
         samples.valid = 1'b0;
      end
      @(negedge clock);
      samples.valid    = 1'b1;
      samples.sample   = value;
      samples.line_end = last;
      do @(posedge clock); while (!samples.ready);
      predict_derivative(value, last);
      sample_count++;
   endtask

   task automatic wait_idle;
      @(negedge clock);
      samples.valid = 1'b0;
      while (expected_derivs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input sgd_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TAP_ORDER:   cfg_order = value[2:0];
         REG_INV_SPACING: cfg_inv = value[23:0];
         default:         cfg_weight[int'(idx) - int'(REG_WEIGHT_1)] = value[17:0];
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic [2:0] order, input logic [23:0] inv);
      int i;
      wait_idle();
      write_reg(REG_TAP_ORDER, 32'(order));
      for (i = 0; i < NUM_WEIGHT_REGS; i++)
         write_reg(sgd_reg_type'(int'(REG_WEIGHT_1) + i), 32'(weight_plan[i]));
      write_reg(REG_INV_SPACING, 32'(inv));
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3, 4: return 24'($signed($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic randomize_config;
      int          i;
      logic [23:0] inv;
      for (i = 0; i < NUM_WEIGHT_REGS; i++) begin
         case ($urandom_range(0, 7))
            0:       weight_plan[i] = WEIGHT_MAX;
            1:       weight_plan[i] = WEIGHT_MIN;
            default: weight_plan[i] = 18'($urandom);
         endcase
      end
      case ($urandom_range(0, 5))
         0:       inv = '1;
         1:       inv = INV_RESET;
         2:       inv = '0;
         3:       inv = 24'($urandom_range(0, 65535));
         default: inv = 24'($urandom);
      endcase
      set_config(3'($urandom_range(0, 7)), inv);
   endtask

   task automatic send_line(input int len);
      int i;
      for (i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
   endtask

   // reset register values: order 1, zero weights, so every derivative is zero
   task automatic test_reset_values;
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(24'sd0, 1'b1);
   endtask

   // full scale steps against the most negative weight clip both ways
   task automatic test_saturation;
      weight_plan = '{WEIGHT_MIN, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
      set_config(3'd1, '1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
   endtask

   // lines too short to fill the stencil give nothing
   task automatic test_short_lines;
      weight_plan = '{18'sd65536, -18'sd32768, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
      set_config(3'd2, INV_RESET);
      send_sample(24'sd1000, 1'b0);
      send_sample(-24'sd1000, 1'b0);
      send_sample(24'sd5, 1'b1);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   // order above the limit acts as the limit, order zero acts as one
   task automatic test_order_limits;
      int i;
      weight_plan = '{WEIGHT_MAX, WEIGHT_MIN, WEIGHT_MAX, WEIGHT_MIN, WEIGHT_MAX, WEIGHT_MIN};
      set_config(3'd7, 24'd1);
      for (i = 0; i < 12; i++) send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, i == 11);
      set_config(3'd0, '0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   // long output stall at full input rate, then a pause until all results are back
   task automatic test_back_pressure;
      int i;
      randomize_config();
      send_gap_max    = 0;
      rsp_gap_max     = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (i = 0; i < 3; i++) send_line(20);
      wait_idle();
   endtask

   task automatic test_random_lines;
      int phase;
      int sent;
      int len;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         randomize_config();
         send_gap_max = (phase % 3 == 0) ? 0 : 8;
         rsp_gap_max  = (phase % 3 == 1) ? 0 : 8;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            send_line(len);
            sent += len;
         end
      end
   endtask

   // result side: random stalls per transaction, plus the long hold on request
   initial begin : result_sink
      int gap;
      derivs.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            derivs.ready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            derivs.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         derivs.ready = 1'b1;
         do @(posedge clock); while (!derivs.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_derivatives
      deriv_result_type want;
      if (!reset && derivs.valid && derivs.ready) begin
         checked_count++;
         if (expected_derivs.size() == 0) begin
            report_mismatch("unexpected derivative", derivs.derivative, '0);
         end else begin
            want = expected_derivs.pop_front();
            if (want.last_in_line) marked_count++;
            if (want.saturated) clipped_count++;
            if (derivs.derivative !== want.derivative)
               report_mismatch("derivative", derivs.derivative, want.derivative);
            if (derivs.last_in_line !== want.last_in_line)
               report_mismatch("last_in_line", 32'(derivs.last_in_line), 32'(want.last_in_line));
            if (derivs.saturated !== want.saturated)
               report_mismatch("saturated", 32'(derivs.saturated), 32'(want.saturated));
         end
      end
   end

   always @(posedge clock) begin
      if ((samples.valid && samples.ready) || (derivs.valid && derivs.ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_derivs.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      samples.valid    = 1'b0;
      samples.sample   = '0;
      samples.line_end = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_saturation();
      test_short_lines();
      test_order_limits();
      test_back_pressure();
      test_random_lines();
      wait_idle();

      $display("sent %0d samples, checked %0d derivatives (%0d line ends, %0d clipped)",
               sample_count, checked_count, marked_count, clipped_count);
      $display("orders 0 to 7, weight and spacing extremes, short lines, %0d-cycle output hold",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
